>>> hw/rtl/rct_pkg.sv
`default_nettype none
package rct_pkg;

	localparam int COORD_BITS = 32;
	localparam int UNIT_BITS = 30;
	localparam logic [31:0] HELPER_THRESH = 32'd966367642;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	// Unit vector component, signed Q2.30.
	typedef logic signed [31:0] unit_t;
	// Input component of the normalizing unit.
	typedef logic signed [33:0] nvec_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		coord_t nx;
		coord_t ny;
		coord_t nz;
		logic [COORD_BITS-1:0] wd;
		logic [COORD_BITS-1:0] ht;
		logic [7:0] c1;
		logic [7:0] c2;
		logic zero;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic load;
		coord_t [2:0] a;
		coord_t [2:0] b;
		coord_t [2:0] c;
		coord_t [2:0] d;
		logic [7:0] c1;
		logic [7:0] c2;
		logic degen;
	} tri_load_t;

	typedef enum logic [2:0] {
		NS_IDLE,
		NS_SHIFT,
		NS_SQ,
		NS_SQRT,
		NS_DIV
	} norm_state_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_N1,
		BS_N2,
		BS_CROSS,
		BS_N3,
		BS_HALF,
		BS_CORNER
	} back_state_t;

	function automatic coord_t sat_coord(input logic signed [34:0] x);
		coord_t r;
		if ((x[34:31] == 4'b0000) || (x[34:31] == 4'b1111)) begin
			r = x[31:0];
		end else if (x[34]) begin
			r = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rct_front.sv
`default_nettype none
module rct_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire rct_pkg::coord_t center_x,
	input wire rct_pkg::coord_t center_y,
	input wire rct_pkg::coord_t center_z,
	input wire rct_pkg::coord_t normal_x,
	input wire rct_pkg::coord_t normal_y,
	input wire rct_pkg::coord_t normal_z,
	input wire logic [31:0] rect_width,
	input wire logic [31:0] rect_height,
	input wire logic [7:0] first_color,
	input wire logic [7:0] second_color,
	output rct_pkg::head_t head,
	input wire logic pop
);

	rct_pkg::item_t mem_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] count_q;
	logic push;
	rct_pkg::item_t in_item;

	assign busy = (count_q == 2'd2);
	assign push = start & ~busy;

	// A zero normal is marked here so the back end can skip the arithmetic.
	always_comb begin
		in_item.cx = center_x;
		in_item.cy = center_y;
		in_item.cz = center_z;
		in_item.nx = normal_x;
		in_item.ny = normal_y;
		in_item.nz = normal_z;
		in_item.wd = rect_width;
		in_item.ht = rect_height;
		in_item.c1 = first_color;
		in_item.c2 = second_color;
		in_item.zero = (normal_x == '0) && (normal_y == '0) && (normal_z == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item = mem_q[rptr_q];

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("queue popped while empty");

endmodule
`default_nettype wire

>>> hw/rtl/rct_norm.sv
`default_nettype none
module rct_norm (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire rct_pkg::nvec_t [2:0] vec,
	output logic done,
	output logic ok,
	output rct_pkg::unit_t [2:0] unit
);

	rct_pkg::norm_state_t state_q;
	rct_pkg::norm_state_t state_d;

	logic [2:0][33:0] m_q;
	logic [2:0] neg_q;
	logic [1:0] idx_q;
	logic [63:0] x_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [4:0] cnt_q;
	logic [30:0] len_q;
	logic [2:0][30:0] rem_q;
	logic [2:0][30:0] lo_q;
	logic done_q;
	logic ok_q;
	rct_pkg::unit_t [2:0] unit_q;

	logic any_hi;
	logic all_lo;
	logic is_zero;
	logic [59:0] sq;
	logic [63:0] sq_t;
	logic sq_take;
	logic [63:0] r_next;
	logic [2:0][31:0] dt;
	logic [2:0] qb;
	logic [2:0][30:0] rem_next;
	logic [2:0][30:0] lo_next;

	assign any_hi = (m_q[0][33:30] != '0) || (m_q[1][33:30] != '0) || (m_q[2][33:30] != '0);
	assign all_lo = (m_q[0][33:29] == '0) && (m_q[1][33:29] == '0) && (m_q[2][33:29] == '0);
	assign is_zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
	assign sq = m_q[idx_q][29:0] * m_q[idx_q][29:0];

	// One digit pair of the integer square root per cycle.
	assign sq_t = r_q + bit_q;
	assign sq_take = (x_q >= sq_t);
	assign r_next = sq_take ? ((r_q >> 1) + bit_q) : (r_q >> 1);

	// Three restoring dividers share the length; one quotient bit per cycle.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dt[i] = {rem_q[i], lo_q[i][30]};
			qb[i] = (dt[i] >= {1'b0, len_q});
			rem_next[i] = qb[i] ? 31'(dt[i] - {1'b0, len_q}) : dt[i][30:0];
			lo_next[i] = {lo_q[i][29:0], qb[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rct_pkg::NS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rct_pkg::NS_IDLE: begin
				if (start && !is_zero) begin
					state_d = rct_pkg::NS_SHIFT;
				end
			end
			rct_pkg::NS_SHIFT: begin
				if (!any_hi && !all_lo) begin
					state_d = rct_pkg::NS_SQ;
				end
			end
			rct_pkg::NS_SQ: begin
				if (idx_q == 2'd2) begin
					state_d = rct_pkg::NS_SQRT;
				end
			end
			rct_pkg::NS_SQRT: begin
				if (cnt_q == 5'd31) begin
					state_d = rct_pkg::NS_DIV;
				end
			end
			rct_pkg::NS_DIV: begin
				if (cnt_q == 5'd30) begin
					state_d = rct_pkg::NS_IDLE;
				end
			end
			default: state_d = rct_pkg::NS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == rct_pkg::NS_IDLE && start && is_zero) begin
				done_q <= 1'b1;
				ok_q <= 1'b0;
			end else if (state_q == rct_pkg::NS_DIV && cnt_q == 5'd30) begin
				done_q <= 1'b1;
				ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rct_pkg::NS_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= vec[i][33] ? 34'(-vec[i]) : 34'(vec[i]);
					neg_q[i] <= vec[i][33];
				end
			end
			rct_pkg::NS_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					if (any_hi) begin
						m_q[i] <= m_q[i] >> 1;
					end else if (all_lo) begin
						m_q[i] <= m_q[i] << 1;
					end
				end
				idx_q <= 2'd0;
				x_q <= '0;
				r_q <= '0;
				bit_q <= 64'd1 << 62;
				cnt_q <= 5'd0;
			end
			rct_pkg::NS_SQ: begin
				x_q <= x_q + {4'd0, sq};
				idx_q <= idx_q + 2'd1;
			end
			rct_pkg::NS_SQRT: begin
				if (sq_take) begin
					x_q <= x_q - sq_t;
				end
				r_q <= r_next;
				bit_q <= bit_q >> 2;
				if (cnt_q == 5'd31) begin
					// Dividend is m * 2^30 + floor(len / 2); its top bits are m >> 1.
					len_q <= r_next[30:0];
					for (int i = 0; i < 3; i++) begin
						rem_q[i] <= {2'd0, m_q[i][29:1]};
						lo_q[i] <= {m_q[i][0], r_next[30:1]};
					end
					cnt_q <= 5'd0;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			rct_pkg::NS_DIV: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= rem_next[i];
					lo_q[i] <= lo_next[i];
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					for (int i = 0; i < 3; i++) begin
						unit_q[i] <= neg_q[i] ? -{1'b0, lo_next[i]} : {1'b0, lo_next[i]};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign ok = ok_q;
	assign unit = unit_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == rct_pkg::NS_IDLE)
		else $error("normalizer started while working");

endmodule
`default_nettype wire

>>> hw/rtl/rct_back.sv
`default_nettype none
module rct_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire rct_pkg::head_t head,
	output logic pop,
	input wire logic emit_free,
	output rct_pkg::tri_load_t ld
);

	rct_pkg::back_state_t state_q;
	rct_pkg::back_state_t state_d;

	rct_pkg::item_t item_q;
	logic ok_q;
	logic [2:0] k_q;
	rct_pkg::unit_t [2:0] n_q;
	rct_pkg::unit_t [2:0] uh_q;
	rct_pkg::unit_t [2:0] vh_q;
	rct_pkg::nvec_t [2:0] w_q;
	logic signed [65:0] acc_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] half_q [6];

	logic norm_start;
	rct_pkg::nvec_t [2:0] norm_vec;
	logic norm_done;
	logic norm_ok;
	rct_pkg::unit_t [2:0] norm_unit;

	logic load_tri;
	rct_pkg::nvec_t [2:0] pvec;
	rct_pkg::nvec_t [2:0] nvec_in;
	logic [31:0] ny_mag;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic [2:0] km1;
	logic [1:0] hidx;
	logic signed [66:0] cdiff;
	logic [66:0] cmag;
	logic [66:0] crnd;
	rct_pkg::nvec_t cw;
	logic [62:0] hsum;
	logic [32:0] hmag;
	logic hneg;
	logic [2:0][31:0] uh_mag;
	logic [2:0][31:0] vh_mag;
	logic signed [34:0] cs [3];
	logic signed [34:0] us [3];
	logic signed [34:0] vs [3];

	rct_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(norm_start),
		.vec(norm_vec),
		.done(norm_done),
		.ok(norm_ok),
		.unit(norm_unit)
	);

	// Helper axis is X when the normal points mostly along Y.
	always_comb begin
		ny_mag = norm_unit[1][31] ? 32'(-norm_unit[1]) : 32'(norm_unit[1]);
		if (ny_mag >= rct_pkg::HELPER_THRESH) begin
			pvec[0] = '0;
			pvec[1] = {{2{norm_unit[2][31]}}, norm_unit[2]};
			pvec[2] = -{{2{norm_unit[1][31]}}, norm_unit[1]};
		end else begin
			pvec[0] = -{{2{norm_unit[2][31]}}, norm_unit[2]};
			pvec[1] = '0;
			pvec[2] = {{2{norm_unit[0][31]}}, norm_unit[0]};
		end
		nvec_in[0] = {{2{head.item.nx[31]}}, head.item.nx};
		nvec_in[1] = {{2{head.item.ny[31]}}, head.item.ny};
		nvec_in[2] = {{2{head.item.nz[31]}}, head.item.nz};
		for (int i = 0; i < 3; i++) begin
			uh_mag[i] = uh_q[i][31] ? 32'(-uh_q[i]) : 32'(uh_q[i]);
			vh_mag[i] = vh_q[i][31] ? 32'(-vh_q[i]) : 32'(vh_q[i]);
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == rct_pkg::BS_CROSS) begin
			case (k_q)
				3'd0: begin mul_a = 33'(n_q[1]); mul_b = 33'(uh_q[2]); end
				3'd1: begin mul_a = 33'(n_q[2]); mul_b = 33'(uh_q[1]); end
				3'd2: begin mul_a = 33'(n_q[2]); mul_b = 33'(uh_q[0]); end
				3'd3: begin mul_a = 33'(n_q[0]); mul_b = 33'(uh_q[2]); end
				3'd4: begin mul_a = 33'(n_q[0]); mul_b = 33'(uh_q[1]); end
				3'd5: begin mul_a = 33'(n_q[1]); mul_b = 33'(uh_q[0]); end
				default: begin end
			endcase
		end else begin
			case (k_q)
				3'd0, 3'd1, 3'd2: begin
					mul_a = {1'b0, uh_mag[k_q[1:0]]};
					mul_b = {1'b0, item_q.wd};
				end
				3'd3, 3'd4, 3'd5: begin
					mul_a = {1'b0, vh_mag[2'(k_q - 3'd3)]};
					mul_b = {1'b0, item_q.ht};
				end
				default: begin end
			endcase
		end
	end

	// Cross product component, rounded from Q4.60 to Q2.30 on the magnitude.
	always_comb begin
		km1 = k_q - 3'd1;
		hidx = (km1 < 3'd3) ? km1[1:0] : 2'(km1 - 3'd3);
		cdiff = 67'(acc_q) - 67'(prod_q);
		cmag = cdiff[66] ? 67'(-cdiff) : 67'(cdiff);
		crnd = (cmag + 67'd536870912) >> 30;
		cw = cdiff[66] ? -34'(crnd[33:0]) : 34'(crnd[33:0]);
		hsum = prod_q[62:0] + 63'd1073741824;
		hmag = {1'b0, hsum[62:31]};
		hneg = (km1 < 3'd3) ? uh_q[hidx][31] : vh_q[hidx][31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rct_pkg::BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		norm_start = 1'b0;
		norm_vec = nvec_in;
		load_tri = 1'b0;
		unique case (state_q)
			rct_pkg::BS_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.item.zero) begin
						state_d = rct_pkg::BS_CORNER;
					end else begin
						norm_start = 1'b1;
						state_d = rct_pkg::BS_N1;
					end
				end
			end
			rct_pkg::BS_N1: begin
				if (norm_done) begin
					if (!norm_ok) begin
						state_d = rct_pkg::BS_CORNER;
					end else begin
						norm_start = 1'b1;
						norm_vec = pvec;
						state_d = rct_pkg::BS_N2;
					end
				end
			end
			rct_pkg::BS_N2: begin
				if (norm_done) begin
					state_d = norm_ok ? rct_pkg::BS_CROSS : rct_pkg::BS_CORNER;
				end
			end
			rct_pkg::BS_CROSS: begin
				if (k_q == 3'd7) begin
					norm_start = 1'b1;
					norm_vec = w_q;
					state_d = rct_pkg::BS_N3;
				end
			end
			rct_pkg::BS_N3: begin
				if (norm_done) begin
					state_d = norm_ok ? rct_pkg::BS_HALF : rct_pkg::BS_CORNER;
				end
			end
			rct_pkg::BS_HALF: begin
				if (k_q == 3'd6) begin
					state_d = rct_pkg::BS_CORNER;
				end
			end
			rct_pkg::BS_CORNER: begin
				if (emit_free) begin
					load_tri = 1'b1;
					state_d = rct_pkg::BS_IDLE;
				end
			end
			default: state_d = rct_pkg::BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
			k_q <= 3'd0;
		end else begin
			case (state_q)
				rct_pkg::BS_IDLE: begin
					if (head.valid) begin
						ok_q <= ~head.item.zero;
					end
					k_q <= 3'd0;
				end
				rct_pkg::BS_N1, rct_pkg::BS_N2, rct_pkg::BS_N3: begin
					if (norm_done && !norm_ok) begin
						ok_q <= 1'b0;
					end
					k_q <= 3'd0;
				end
				rct_pkg::BS_CROSS, rct_pkg::BS_HALF: begin
					k_q <= k_q + 3'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 66'(mul_a * mul_b);
		case (state_q)
			rct_pkg::BS_IDLE: begin
				if (head.valid) begin
					item_q <= head.item;
				end
			end
			rct_pkg::BS_N1: begin
				if (norm_done) begin
					n_q <= norm_unit;
				end
			end
			rct_pkg::BS_N2: begin
				if (norm_done) begin
					uh_q <= norm_unit;
				end
			end
			rct_pkg::BS_N3: begin
				if (norm_done) begin
					vh_q <= norm_unit;
				end
			end
			rct_pkg::BS_CROSS: begin
				if (k_q != 3'd0 && k_q != 3'd7) begin
					if (!km1[0]) begin
						acc_q <= prod_q;
					end else begin
						w_q[km1[2:1]] <= cw;
					end
				end
			end
			rct_pkg::BS_HALF: begin
				if (k_q != 3'd0 && k_q != 3'd7) begin
					half_q[km1] <= hneg ? -33'(hmag) : 33'(hmag);
				end
			end
			default: begin
			end
		endcase
	end

	// Corners are exact sums, saturated; a zero normal or a failed normalization gives zeros.
	always_comb begin
		ld.load = load_tri;
		cs[0] = 35'(item_q.cx);
		cs[1] = 35'(item_q.cy);
		cs[2] = 35'(item_q.cz);
		for (int i = 0; i < 3; i++) begin
			us[i] = 35'(half_q[i]);
			vs[i] = 35'(half_q[i + 3]);
			if (ok_q) begin
				ld.a[i] = rct_pkg::sat_coord(cs[i] + us[i] + vs[i]);
				ld.b[i] = rct_pkg::sat_coord(cs[i] - us[i] - vs[i]);
				ld.c[i] = rct_pkg::sat_coord(cs[i] - us[i] + vs[i]);
				ld.d[i] = rct_pkg::sat_coord(cs[i] + us[i] - vs[i]);
			end else begin
				ld.a[i] = '0;
				ld.b[i] = '0;
				ld.c[i] = '0;
				ld.d[i] = '0;
			end
		end
		ld.c1 = item_q.c1;
		ld.c2 = item_q.c2;
		ld.degen = ~ok_q;
	end

endmodule
`default_nettype wire

>>> hw/rtl/rct_emit.sv
`default_nettype none
module rct_emit (
	input wire logic clk,
	input wire logic arst_n,
	input wire rct_pkg::tri_load_t ld,
	output logic free,
	output logic result_strobe,
	output rct_pkg::coord_t vert0_x,
	output rct_pkg::coord_t vert0_y,
	output rct_pkg::coord_t vert0_z,
	output rct_pkg::coord_t vert1_x,
	output rct_pkg::coord_t vert1_y,
	output rct_pkg::coord_t vert1_z,
	output rct_pkg::coord_t vert2_x,
	output rct_pkg::coord_t vert2_y,
	output rct_pkg::coord_t vert2_z,
	output logic [7:0] tri_color,
	output logic last_tri,
	output logic degenerate
);

	logic valid_q;
	logic phase_q;
	rct_pkg::coord_t [2:0] a_q;
	rct_pkg::coord_t [2:0] b_q;
	rct_pkg::coord_t [2:0] c_q;
	rct_pkg::coord_t [2:0] d_q;
	logic [7:0] c1_q;
	logic [7:0] c2_q;
	logic degen_q;

	// A new pair may load in the cycle that the second triangle goes out.
	assign free = ~valid_q | phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (ld.load) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (valid_q && !phase_q) begin
			phase_q <= 1'b1;
		end else begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			a_q <= ld.a;
			b_q <= ld.b;
			c_q <= ld.c;
			d_q <= ld.d;
			c1_q <= ld.c1;
			c2_q <= ld.c2;
			degen_q <= ld.degen;
		end
	end

	assign result_strobe = valid_q;
	assign vert0_x = phase_q ? b_q[0] : a_q[0];
	assign vert0_y = phase_q ? b_q[1] : a_q[1];
	assign vert0_z = phase_q ? b_q[2] : a_q[2];
	assign vert1_x = phase_q ? a_q[0] : b_q[0];
	assign vert1_y = phase_q ? a_q[1] : b_q[1];
	assign vert1_z = phase_q ? a_q[2] : b_q[2];
	assign vert2_x = phase_q ? d_q[0] : c_q[0];
	assign vert2_y = phase_q ? d_q[1] : c_q[1];
	assign vert2_z = phase_q ? d_q[2] : c_q[2];
	assign tri_color = phase_q ? c2_q : c1_q;
	assign last_tri = phase_q;
	assign degenerate = degen_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld.load |-> free)
		else $error("pair loaded over one not yet sent");
	a_phase_valid: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_q)
		else $error("second triangle without a held pair");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && phase_q) |-> $past(valid_q && !phase_q))
		else $error("second triangle not preceded by the first");

endmodule
`default_nettype wire

>>> hw/rtl/rectangle_corner_triangles.sv
// Channel   Handshake            Payload
// input     start, busy          center_x/y/z, normal_x/y/z, rect_width, rect_height,
//                                first_color, second_color
// result    result_strobe        vert0..vert2 x/y/z, tri_color, last_tri, degenerate
//
// An item is taken when start is high and busy is low; a two-entry queue holds items
// while the back end works, so busy rises only when both entries are taken.
// An item with a nonzero normal is popped and then takes three passes of the shared
// normalizer (shift, three squares, 32-step square root, 31-step divide): one on the
// normal, one on the first in-plane axis, and after the cross product one on the second
// axis; the half axes and the corners follow. A zero normal skips the arithmetic.
// Each item yields two results on consecutive cycles; the receiver cannot stall.
// arst_n clears the queue, the sequencers and the emitter; no clearing pass is needed.
`default_nettype none
module rectangle_corner_triangles (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire rct_pkg::coord_t center_x,
	input wire rct_pkg::coord_t center_y,
	input wire rct_pkg::coord_t center_z,
	input wire rct_pkg::coord_t normal_x,
	input wire rct_pkg::coord_t normal_y,
	input wire rct_pkg::coord_t normal_z,
	input wire logic [31:0] rect_width,
	input wire logic [31:0] rect_height,
	input wire logic [7:0] first_color,
	input wire logic [7:0] second_color,
	output logic result_strobe,
	output rct_pkg::coord_t vert0_x,
	output rct_pkg::coord_t vert0_y,
	output rct_pkg::coord_t vert0_z,
	output rct_pkg::coord_t vert1_x,
	output rct_pkg::coord_t vert1_y,
	output rct_pkg::coord_t vert1_z,
	output rct_pkg::coord_t vert2_x,
	output rct_pkg::coord_t vert2_y,
	output rct_pkg::coord_t vert2_z,
	output logic [7:0] tri_color,
	output logic last_tri,
	output logic degenerate
);

	rct_pkg::head_t head;
	logic pop;
	logic emit_free;
	rct_pkg::tri_load_t ld;

	rct_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.first_color(first_color),
		.second_color(second_color),
		.head(head),
		.pop(pop)
	);

	rct_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.emit_free(emit_free),
		.ld(ld)
	);

	rct_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.ld(ld),
		.free(emit_free),
		.result_strobe(result_strobe),
		.vert0_x(vert0_x),
		.vert0_y(vert0_y),
		.vert0_z(vert0_z),
		.vert1_x(vert1_x),
		.vert1_y(vert1_y),
		.vert1_z(vert1_z),
		.vert2_x(vert2_x),
		.vert2_y(vert2_y),
		.vert2_z(vert2_z),
		.tri_color(tri_color),
		.last_tri(last_tri),
		.degenerate(degenerate)
	);

endmodule
`default_nettype wire
